// File: hdl/rf_tuning_frequency_plan_core_macros.svh
// assertion helpers shared by the frequency plan modules
`ifndef RF_TUNING_FREQUENCY_PLAN_CORE_MACROS_SVH
`define RF_TUNING_FREQUENCY_PLAN_CORE_MACROS_SVH

// condition holds at every edge outside reset
`define RFTFP_ASSERT_NOW(label, clk_s, rst_s, cond, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RFTFP_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define RFTFP_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/rftfp_pkg.sv
`timescale 1ns / 1ps
package rftfp_pkg;

  // register targets of one write
  typedef enum logic [1:0] {
    TGT_STAGE0 = 2'd0,
    TGT_STAGE1 = 2'd1,
    TGT_STAGE2 = 2'd2,
    TGT_INV    = 2'd3
  } target_t;

  typedef struct packed {
    logic        channel;
    logic [35:0] freq_hz;
  } in_item_t;

  typedef struct packed {
    target_t     target;
    logic [21:0] value;
    logic        for_channel;
    logic        last;
  } out_item_t;

  // classified request between front and back
  typedef struct packed {
    logic        channel;
    logic [35:0] freq_hz;
    logic        high;      // channel 1 at or above 18 GHz
    logic [21:0] start_w;   // band start in 10 kHz units
    logic [19:0] base_w;    // IF + 20 MHz in 10 kHz units
    logic        fine_up;   // above 32020 MHz: remainder is added
    logic        inv;       // spectrum inversion flag
  } fe_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CALC,
    ST_WORD,
    ST_EMIT_HEAD,
    ST_EMIT_S1,
    ST_EMIT_INV
  } be_state_t;

  localparam logic [35:0] MHZ_HZ       = 36'd1000000;
  localparam logic [35:0] MAX_HZ       = 36'd40000000000;
  localparam logic [35:0] HIGH_BAND_HZ = 36'd18000000000;
  localparam logic [35:0] INV_LOW_HZ   = 36'd13000000000;
  localparam logic [35:0] INV_HIGH_HZ  = 36'd32020000000;
  localparam logic [35:0] OVR_A_HZ     = 36'd34040000000;
  localparam logic [35:0] OVR_B_HZ     = 36'd30540000000;

  localparam logic [15:0] OVR_A_MHZ        = 16'd34040;
  localparam logic [15:0] OVR_A_IF_MHZ     = 16'd7860;
  localparam logic [15:0] OVR_B_MHZ        = 16'd30540;
  localparam logic [15:0] OVR_B_IF_MHZ     = 16'd5800;
  localparam logic [15:0] FALLBACK_MHZ     = 16'd18000;
  localparam logic [15:0] FALLBACK_IF_MHZ  = 16'd7860;
  localparam logic [15:0] OFFSET_MHZ       = 16'd20;
  localparam logic [21:0] MHZ_WORDS        = 22'd100;

  localparam int NUM_BANDS = 15;
  localparam logic [15:0] BAND_LO_MHZ [NUM_BANDS] = '{
    16'd18000, 16'd19000, 16'd19020, 16'd26500, 16'd26520,
    16'd30500, 16'd30540, 16'd32000, 16'd32020, 16'd32060,
    16'd34000, 16'd34040, 16'd38600, 16'd38620, 16'd38660};
  localparam logic [15:0] BAND_HI_MHZ [NUM_BANDS] = '{
    16'd19000, 16'd19020, 16'd26500, 16'd26520, 16'd30500,
    16'd30540, 16'd32000, 16'd32020, 16'd32060, 16'd34000,
    16'd34040, 16'd38600, 16'd38620, 16'd38660, 16'd40000};
  localparam logic [15:0] BAND_IF_MHZ [NUM_BANDS] = '{
    16'd7860, 16'd7860, 16'd5800, 16'd5800, 16'd7860,
    16'd7860, 16'd5800, 16'd5800, 16'd5800, 16'd5800,
    16'd5800, 16'd7860, 16'd7860, 16'd5800, 16'd5800};

  // word arithmetic
  localparam logic [21:0] LOW_LO_WORD = 22'd1300000;
  localparam logic [11:0] STEP_WORD   = 12'd4000;
  localparam logic [17:0] RECIP_125   = 18'd134218;  // ceil(2^24 / 125)
  localparam int          RECIP_SHIFT = 24;
  localparam int          PROD_W      = 35;
  localparam int          K_W         = 11;

  // divide by 10 000, restoring, several quotient bits per cycle
  localparam logic [14:0] WORD_DIV     = 15'd10000;
  localparam int          DIV_BITS     = 6;
  localparam int          DIV_CYCLES   = 4;
  localparam int          DIV_LOW_W    = DIV_BITS * DIV_CYCLES;
  localparam int          DIV_REM_W    = 14;
  localparam int          DIV_CNT_W    = $clog2(DIV_CYCLES);

endpackage

// File: hdl/rftfp_front.sv
`timescale 1ns / 1ps
module rftfp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rftfp_pkg::in_item_t in_data,
  output logic                fe_valid,
  input  logic                fe_ready,
  output rftfp_pkg::fe_item_t fe_item
);

  logic                valid_r, valid_nxt;
  rftfp_pkg::fe_item_t item_r, item_nxt;
  logic                load;
  logic                ignore;
  logic [15:0]         start_mhz;
  logic [15:0]         if_mhz;
  logic [35:0]         f;

  assign f        = in_data.freq_hz;
  assign in_ready = !valid_r || fe_ready;
  assign load     = in_valid && in_ready;
  assign ignore   = f > rftfp_pkg::MAX_HZ;

  // band lookup with two exact-frequency overrides, bands are disjoint
  always_comb begin
    start_mhz = rftfp_pkg::FALLBACK_MHZ;
    if_mhz    = rftfp_pkg::FALLBACK_IF_MHZ;
    for (int i = 0; i < rftfp_pkg::NUM_BANDS; i++) begin
      if (f > 36'(rftfp_pkg::BAND_LO_MHZ[i]) * rftfp_pkg::MHZ_HZ &&
          f <= 36'(rftfp_pkg::BAND_HI_MHZ[i]) * rftfp_pkg::MHZ_HZ) begin
        start_mhz = rftfp_pkg::BAND_LO_MHZ[i];
        if_mhz    = rftfp_pkg::BAND_IF_MHZ[i];
      end
    end
    if (f == rftfp_pkg::OVR_A_HZ) begin
      start_mhz = rftfp_pkg::OVR_A_MHZ;
      if_mhz    = rftfp_pkg::OVR_A_IF_MHZ;
    end else if (f == rftfp_pkg::OVR_B_HZ) begin
      start_mhz = rftfp_pkg::OVR_B_MHZ;
      if_mhz    = rftfp_pkg::OVR_B_IF_MHZ;
    end
  end

  always_comb begin
    item_nxt = item_r;
    if (load) begin
      item_nxt.channel = in_data.channel;
      item_nxt.freq_hz = f;
      item_nxt.high    = in_data.channel && (f >= rftfp_pkg::HIGH_BAND_HZ);
      item_nxt.start_w = 22'(start_mhz) * rftfp_pkg::MHZ_WORDS;
      item_nxt.base_w  = 20'(22'(if_mhz + rftfp_pkg::OFFSET_MHZ) * rftfp_pkg::MHZ_WORDS);
      item_nxt.fine_up = f > rftfp_pkg::INV_HIGH_HZ;
      item_nxt.inv     = (f >= rftfp_pkg::INV_LOW_HZ) && (f <= rftfp_pkg::INV_HIGH_HZ);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = !ignore;
    end else if (fe_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign fe_valid = valid_r;
  assign fe_item  = item_r;

endmodule

// File: hdl/rftfp_queue.sv
`timescale 1ns / 1ps
`include "rf_tuning_frequency_plan_core_macros.svh"
module rftfp_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  rftfp_pkg::fe_item_t push_item,
  output logic                pop_valid,
  input  logic                pop,
  output rftfp_pkg::fe_item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rftfp_pkg::fe_item_t mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                push;

  assign push_ready = cnt_r != CNT_W'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `RFTFP_ASSERT_NOW(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(DEPTH), "queue count overflow")
  `RFTFP_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, pop, cnt_r != '0, "pop from empty queue")
  `RFTFP_ASSERT_NEXT(a_cnt_up, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + CNT_W'(1), "queue count missed a push")
  `RFTFP_ASSERT_NEXT(a_cnt_down, clk, rst_n, pop && !push, cnt_r == $past(cnt_r) - CNT_W'(1), "queue count missed a pop")

endmodule

// File: hdl/rftfp_div.sv
`timescale 1ns / 1ps
module rftfp_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [35:0]                         dividend,
  output logic                                fin,
  output logic [21:0]                         quot,
  output logic [rftfp_pkg::DIV_REM_W-1:0]     rem
);

  localparam int LOW_W = rftfp_pkg::DIV_LOW_W;
  localparam int REM_W = rftfp_pkg::DIV_REM_W;
  localparam int CNT_W = rftfp_pkg::DIV_CNT_W;

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [LOW_W-1:0] dvd_r, dvd_nxt;
  logic [LOW_W-1:0] quot_r, quot_nxt;
  logic [REM_W-1:0] rem_step;
  logic [LOW_W-1:0] dvd_step;
  logic [LOW_W-1:0] quot_step;

  assign fin = busy_r && (cnt_r == CNT_W'(rftfp_pkg::DIV_CYCLES - 1));

  // a few restoring steps per cycle
  always_comb begin
    logic [REM_W:0] t;
    rem_step  = rem_r;
    dvd_step  = dvd_r;
    quot_step = quot_r;
    for (int j = 0; j < rftfp_pkg::DIV_BITS; j++) begin
      t = {rem_step, dvd_step[LOW_W-1]};
      if (t >= rftfp_pkg::WORD_DIV) begin
        rem_step  = REM_W'(t - rftfp_pkg::WORD_DIV);
        quot_step = {quot_step[LOW_W-2:0], 1'b1};
      end else begin
        rem_step  = t[REM_W-1:0];
        quot_step = {quot_step[LOW_W-2:0], 1'b0};
      end
      dvd_step = {dvd_step[LOW_W-2:0], 1'b0};
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = REM_W'(dividend[35:LOW_W]);
      dvd_nxt  = dividend[LOW_W-1:0];
      quot_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = rem_step;
      dvd_nxt  = dvd_step;
      quot_nxt = quot_step;
      cnt_nxt  = cnt_r + CNT_W'(1);
      if (fin) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    quot_r <= quot_nxt;
  end

  assign quot = quot_r[21:0];
  assign rem  = rem_r;

endmodule

// File: hdl/rftfp_back.sv
`timescale 1ns / 1ps
`include "rf_tuning_frequency_plan_core_macros.svh"
module rftfp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  rftfp_pkg::fe_item_t  q_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rftfp_pkg::out_item_t out_data
);

  rftfp_pkg::be_state_t  state_r, state_nxt;
  rftfp_pkg::fe_item_t   item_r, item_nxt;
  rftfp_pkg::out_item_t  out_data_r, out_data_nxt;
  rftfp_pkg::out_item_t  push_data;
  logic                  out_valid_r, out_valid_nxt;
  logic [21:0]           q_r, q_nxt;
  logic                  rnz_r, rnz_nxt;
  logic [21:0]           dq_r, dq_nxt;
  logic [rftfp_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [21:0]           w_head_r, w_head_nxt;
  logic [21:0]           w1_r, w1_nxt;
  logic [21:0]           last_s1_r, last_s1_nxt;
  logic [1:0]            inv_known_r, inv_known_nxt;
  logic [1:0]            inv_val_r, inv_val_nxt;
  logic                  pend_inv_r, pend_inv_nxt;

  logic                  push_ok;
  logic                  push;
  logic                  pop;
  logic                  fin;
  logic                  need_s1;
  logic                  need_inv;
  logic                  div_fin;
  logic [21:0]           div_quot;
  logic [rftfp_pkg::DIV_REM_W-1:0] div_rem;
  logic [rftfp_pkg::K_W-1:0] k;
  logic [21:0]           rem_raw;
  logic [11:0]           remq;
  logic [21:0]           rough_w;
  logic [21:0]           fine_w;

  rftfp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (pop),
    .dividend (q_item.freq_hz),
    .fin      (div_fin),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign push_ok  = !out_valid_r || out_ready;
  assign need_s1  = item_r.channel && (w1_r != last_s1_r);
  assign need_inv = !inv_known_r[item_r.channel] ||
                    (inv_val_r[item_r.channel] != item_r.inv);

  // final write of the current request goes out this cycle
  always_comb begin
    case (state_r)
      rftfp_pkg::ST_EMIT_HEAD: fin = push_ok && !need_s1 && !need_inv;
      rftfp_pkg::ST_EMIT_S1:   fin = push_ok && !pend_inv_r;
      rftfp_pkg::ST_EMIT_INV:  fin = push_ok;
      default:                 fin = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rftfp_pkg::ST_IDLE: begin
        if (q_valid) state_nxt = rftfp_pkg::ST_DIV;
      end
      rftfp_pkg::ST_DIV: begin
        if (div_fin) state_nxt = rftfp_pkg::ST_CALC;
      end
      rftfp_pkg::ST_CALC: state_nxt = rftfp_pkg::ST_WORD;
      rftfp_pkg::ST_WORD: state_nxt = rftfp_pkg::ST_EMIT_HEAD;
      rftfp_pkg::ST_EMIT_HEAD: begin
        if (push_ok) begin
          if (need_s1)       state_nxt = rftfp_pkg::ST_EMIT_S1;
          else if (need_inv) state_nxt = rftfp_pkg::ST_EMIT_INV;
        end
      end
      rftfp_pkg::ST_EMIT_S1: begin
        if (push_ok && pend_inv_r) state_nxt = rftfp_pkg::ST_EMIT_INV;
      end
      // flag word waits here until the output register frees up
      rftfp_pkg::ST_EMIT_INV: state_nxt = state_r;
      default: state_nxt = rftfp_pkg::ST_IDLE;
    endcase
    if (fin) begin
      state_nxt = q_valid ? rftfp_pkg::ST_DIV : rftfp_pkg::ST_IDLE;
    end
  end

  // state outputs
  always_comb begin
    pop       = 1'b0;
    push      = 1'b0;
    push_data = '{target: rftfp_pkg::TGT_STAGE0, value: w_head_r,
                  for_channel: item_r.channel, last: 1'b1};
    case (state_r)
      rftfp_pkg::ST_IDLE: pop = q_valid;
      rftfp_pkg::ST_EMIT_HEAD: begin
        push = push_ok;
        push_data.target = item_r.channel ? rftfp_pkg::TGT_STAGE2 : rftfp_pkg::TGT_STAGE0;
        push_data.last   = !(need_s1 || need_inv);
      end
      rftfp_pkg::ST_EMIT_S1: begin
        push = push_ok;
        push_data.target = rftfp_pkg::TGT_STAGE1;
        push_data.value  = w1_r;
        push_data.last   = !pend_inv_r;
      end
      rftfp_pkg::ST_EMIT_INV: begin
        push = push_ok;
        push_data.target = rftfp_pkg::TGT_INV;
        push_data.value  = {21'b0, item_r.inv};
      end
      default: pop = 1'b0;
    endcase
    if (fin) begin
      pop = q_valid;
    end
  end

  assign q_pop = pop;

  // 40 MHz split of the offset from the band start, in 10 kHz units
  always_comb begin
    k       = prod_r[rftfp_pkg::RECIP_SHIFT +: rftfp_pkg::K_W];
    rem_raw = dq_r - 22'(k) * 22'(rftfp_pkg::STEP_WORD);
    if (rem_raw >= 22'(rftfp_pkg::STEP_WORD)) begin
      remq = 12'(rem_raw - 22'(rftfp_pkg::STEP_WORD));
    end else begin
      remq = rem_raw[11:0];
    end
    rough_w = q_r - 22'(remq);
    if (item_r.fine_up) begin
      fine_w = 22'(item_r.base_w) + 22'(remq);
    end else begin
      fine_w = 22'(item_r.base_w) - 22'(remq) - 22'(rnz_r);
    end
  end

  always_comb begin
    item_nxt      = pop ? q_item : item_r;
    q_nxt         = q_r;
    rnz_nxt       = rnz_r;
    dq_nxt        = dq_r;
    prod_nxt      = prod_r;
    w_head_nxt    = w_head_r;
    w1_nxt        = w1_r;
    last_s1_nxt   = last_s1_r;
    inv_known_nxt = inv_known_r;
    inv_val_nxt   = inv_val_r;
    pend_inv_nxt  = pend_inv_r;
    out_valid_nxt = push ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    out_data_nxt  = push ? push_data : out_data_r;

    if (state_r == rftfp_pkg::ST_CALC) begin
      q_nxt    = div_quot;
      rnz_nxt  = div_rem != '0;
      dq_nxt   = div_quot - item_r.start_w;
      prod_nxt = rftfp_pkg::PROD_W'(dq_nxt[21:5]) *
                 rftfp_pkg::PROD_W'(rftfp_pkg::RECIP_125);
    end

    if (state_r == rftfp_pkg::ST_WORD) begin
      if (!item_r.channel) begin
        w_head_nxt = q_r;
        w1_nxt     = q_r;
      end else if (item_r.high) begin
        w_head_nxt = rough_w;
        w1_nxt     = fine_w;
      end else begin
        w_head_nxt = rftfp_pkg::LOW_LO_WORD;
        w1_nxt     = q_r;
      end
    end

    // history moves with the first write of a request
    if (state_r == rftfp_pkg::ST_EMIT_HEAD && push) begin
      if (item_r.channel) begin
        last_s1_nxt = w1_r;
      end
      inv_known_nxt[item_r.channel] = 1'b1;
      inv_val_nxt[item_r.channel]   = item_r.inv;
      pend_inv_nxt                  = need_inv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rftfp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      last_s1_r   <= '0;
      inv_known_r <= '0;
      pend_inv_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_s1_r   <= last_s1_nxt;
      inv_known_r <= inv_known_nxt;
      pend_inv_r  <= pend_inv_nxt;
    end
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
    q_r        <= q_nxt;
    rnz_r      <= rnz_nxt;
    dq_r       <= dq_nxt;
    prod_r     <= prod_nxt;
    w_head_r   <= w_head_nxt;
    w1_r       <= w1_nxt;
    inv_val_r  <= inv_val_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RFTFP_ASSERT_IMPL(a_div_fin_state, clk, rst_n, div_fin, state_r == rftfp_pkg::ST_DIV, "divider finished outside divide state")
  `RFTFP_ASSERT_IMPL(a_push_state, clk, rst_n, push, state_r == rftfp_pkg::ST_EMIT_HEAD || state_r == rftfp_pkg::ST_EMIT_S1 || state_r == rftfp_pkg::ST_EMIT_INV, "write pushed outside emit states")
  `RFTFP_ASSERT_NEXT(a_more_writes, clk, rst_n, push && !push_data.last, state_r == rftfp_pkg::ST_EMIT_S1 || state_r == rftfp_pkg::ST_EMIT_INV, "request ended without its last write")
  `RFTFP_ASSERT_IMPL(a_calc_after_div, clk, rst_n, state_r == rftfp_pkg::ST_CALC, $past(div_fin), "calc entered before divide finished")

endmodule

// File: hdl/rf_tuning_frequency_plan_core.sv
`timescale 1ns / 1ps
// frequency plan for a two-stage downconverter: each tuning request (channel, frequency in hz)
// becomes one to three register words in order. channel 0 writes its stage-0 word (frequency in
// 10 khz units); channel 1 writes the stage-2 word, then the stage-1 word only if it differs from
// the previous stage-1 word, and either channel then writes its spectrum inversion flag only if it
// changed for that channel (the first request per channel always writes it). requests above
// 40 ghz give no words and leave the history alone. each word carries its channel and a last
// marker on the final word of a request. a front stage takes a request every cycle unless the
// queue is full, does the band lookup and sends it through a short queue; the back end works on
// one request at a time: a divide by 10 000 (six quotient bits a cycle), the 40 mhz split, the
// word calculation, then one write per word; it pops the next request with the final write.
// results sit in an output register, so the back end keeps going while the last word waits to be
// taken
module rf_tuning_frequency_plan_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rftfp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rftfp_pkg::out_item_t out_data
);

  // front to queue
  logic                fe_valid;
  logic                fe_ready;
  rftfp_pkg::fe_item_t fe_item;

  // queue to back end
  logic                q_valid;
  logic                q_pop;
  rftfp_pkg::fe_item_t q_item;

  // range check, band lookup and inversion flag
  rftfp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .fe_valid (fe_valid),
    .fe_ready (fe_ready),
    .fe_item  (fe_item)
  );

  // decouples classification from word generation
  rftfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_item  (fe_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // divide, split into 40 mhz steps, sequence the writes, keep history
  rftfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
